FILE: design/vfc_pkg.sv
// vfc_pkg: shared constants, codes and types for the voxel face cull block.
`timescale 1ns / 1ps

package vfc_pkg;

    localparam int CUBE_EDGE   = 16;
    localparam int VOXEL_COUNT = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
    localparam int ADDR_W      = $clog2(VOXEL_COUNT);

    localparam int COORD_W = 4;
    localparam int TYPE_W  = 8;
    localparam int MASK_W  = 6;
    localparam int CNT_W   = 3;

    localparam int IN_FIELDS_W  = 3 * COORD_W + TYPE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TYPE_W + MASK_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // item kind, carried on tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // first member lands in the highest bits
    typedef struct packed {
        logic [TYPE_W-1:0]  block_type;
        logic [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  face_count;
        logic [MASK_W-1:0] face_mask;
        logic [TYPE_W-1:0] voxel_type;
    } result_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] wdata;
    } ram_req_t;

endpackage

FILE: design/vfc_ram.sv
// vfc_ram: generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module vfc_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/vfc_ctrl.sv
// vfc_ctrl: clearing pass, write and seven-read query sequencer over the voxel RAM.
`timescale 1ns / 1ps

module vfc_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_kind,
    input  vfc_pkg::item_t           in_item,
    output vfc_pkg::ram_req_t        ram_req,
    input  logic [vfc_pkg::TYPE_W-1:0] ram_rdata,
    output logic                     res_valid,
    input  logic                     res_ready,
    output vfc_pkg::result_t         res
);

    localparam int NC_W = vfc_pkg::COORD_W + 1;

    // read order: center, then +x, -x, +y, -y, +z, -z
    localparam logic [2:0] STEP_CTR = 3'd0;
    localparam logic [2:0] STEP_XP  = 3'd1;
    localparam logic [2:0] STEP_XM  = 3'd2;
    localparam logic [2:0] STEP_YP  = 3'd3;
    localparam logic [2:0] STEP_YM  = 3'd4;
    localparam logic [2:0] STEP_ZP  = 3'd5;
    localparam logic [2:0] STEP_ZM  = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [vfc_pkg::ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [2:0]                   step_reg, step_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [2:0]                   rd_step_reg, rd_step_next;
    logic                         rd_out_reg, rd_out_next;
    vfc_pkg::item_t               item_reg, item_next;
    logic [vfc_pkg::TYPE_W-1:0]   here_reg, here_next;
    logic [vfc_pkg::MASK_W-1:0]   nb_empty_reg, nb_empty_next;

    logic [NC_W-1:0]              cx, cy, cz, nx, ny, nz;
    logic                         under;
    logic                         outside;
    logic [vfc_pkg::ADDR_W-1:0]   rd_addr;
    logic [vfc_pkg::MASK_W-1:0]   mask;
    logic                         accept;
    logic                         in_inside;

    function automatic logic [vfc_pkg::ADDR_W-1:0] cell_index(
        input logic [NC_W-1:0] x,
        input logic [NC_W-1:0] y,
        input logic [NC_W-1:0] z
    );
        int idx;
        idx = (int'(x) * vfc_pkg::CUBE_EDGE + int'(y)) * vfc_pkg::CUBE_EDGE + int'(z);
        return vfc_pkg::ADDR_W'(idx);
    endfunction

    function automatic logic in_cube(
        input logic [NC_W-1:0] x,
        input logic [NC_W-1:0] y,
        input logic [NC_W-1:0] z
    );
        return (int'(x) < vfc_pkg::CUBE_EDGE) && (int'(y) < vfc_pkg::CUBE_EDGE)
            && (int'(z) < vfc_pkg::CUBE_EDGE);
    endfunction

    function automatic logic [vfc_pkg::CNT_W-1:0] popcount(
        input logic [vfc_pkg::MASK_W-1:0] m
    );
        logic [vfc_pkg::CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < vfc_pkg::MASK_W; i++) begin
            c = c + vfc_pkg::CNT_W'(m[i]);
        end
        return c;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_inside = in_cube({1'b0, in_item.pos_x}, {1'b0, in_item.pos_y},
                               {1'b0, in_item.pos_z});

    // neighbour coordinate for the current read step
    always_comb begin
        cx    = {1'b0, item_reg.pos_x};
        cy    = {1'b0, item_reg.pos_y};
        cz    = {1'b0, item_reg.pos_z};
        nx    = cx;
        ny    = cy;
        nz    = cz;
        under = 1'b0;
        case (step_reg)
            STEP_CTR: begin end
            STEP_XP:  nx = cx + NC_W'(1);
            STEP_XM: begin
                nx    = cx - NC_W'(1);
                under = (item_reg.pos_x == '0);
            end
            STEP_YP:  ny = cy + NC_W'(1);
            STEP_YM: begin
                ny    = cy - NC_W'(1);
                under = (item_reg.pos_y == '0);
            end
            STEP_ZP:  nz = cz + NC_W'(1);
            STEP_ZM: begin
                nz    = cz - NC_W'(1);
                under = (item_reg.pos_z == '0);
            end
            default: begin end
        endcase
        outside = under || !in_cube(nx, ny, nz);
        rd_addr = cell_index(nx, ny, nz);
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        step_next     = step_reg;
        rd_vld_next   = 1'b0;
        rd_step_next  = step_reg;
        rd_out_next   = outside;
        item_next     = item_reg;
        here_next     = here_reg;
        nb_empty_next = nb_empty_reg;
        ram_req       = '0;

        // collect the read issued last cycle
        if (rd_vld_reg) begin
            if (rd_step_reg == STEP_CTR) begin
                here_next = rd_out_reg ? '0 : ram_rdata;
            end else begin
                nb_empty_next[3'(rd_step_reg - 3'd1)] = rd_out_reg || (ram_rdata == '0);
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = clr_cnt_reg;
                ram_req.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + vfc_pkg::ADDR_W'(1);
                if (clr_cnt_reg == vfc_pkg::ADDR_W'(vfc_pkg::VOXEL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    item_next = in_item;
                    step_next = STEP_CTR;
                    if (in_kind == vfc_pkg::KIND_WRITE && in_inside) begin
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = cell_index({1'b0, in_item.pos_x},
                                                   {1'b0, in_item.pos_y},
                                                   {1'b0, in_item.pos_z});
                        ram_req.wdata = in_item.block_type;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ram_req.en   = 1'b1;
                ram_req.addr = rd_addr;
                rd_vld_next  = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == STEP_ZM) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mask             = (here_reg != '0) ? nb_empty_reg : '0;
    assign res_valid        = (state_reg == ST_DONE);
    assign res.voxel_type   = here_reg;
    assign res.face_mask    = mask;
    assign res.face_count   = popcount(mask);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_vld_reg  <= rd_vld_next;
        end
        step_reg     <= step_next;
        rd_step_reg  <= rd_step_next;
        rd_out_reg   <= rd_out_next;
        item_reg     <= item_next;
        here_reg     <= here_next;
        nb_empty_reg <= nb_empty_next;
    end

endmodule

FILE: design/voxel_face_cull.sv
// voxel_face_cull: top level with stream ports, voxel RAM, sequencer and output register.
//
// Usage: a 16x16x16 cube of 8-bit block types (0 = empty). Each input transfer
// is one item: tuser = kind (write or query), tdata = x, y, z and block type.
// A write stores the type (ignored if a coordinate is off the cube) and then
// reports like a query of the same voxel. Every item gives one result transfer:
// voxel type, mask of visible faces (+x,-x,+y,-y,+z,-z) and face count.
// Timing: after the item is taken, seven single-port RAM reads (the voxel and
// its six neighbours) run one per cycle, then the result is offered to the output
// register; the next item is taken only once that result has been handed over.
// The single RAM port limits how fast items go through.
// Reset: aresetn low clears control; afterwards a clearing pass writes zero to
// all 4096 voxels, one per cycle, and s_tready stays low until the pass is done.
// Stall: the result sits in the output register until m_tready; meanwhile a new
// item may be taken, and its result waits in the sequencer until the register frees.
`timescale 1ns / 1ps

module voxel_face_cull (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [19:12] block_type, rest zero
    input  logic [vfc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] kind
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] voxel_type, [13:8] face_mask, [16:14] face_count, rest zero
    output logic [vfc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    vfc_pkg::item_t            in_item;
    vfc_pkg::ram_req_t         ram_req;
    logic [vfc_pkg::TYPE_W-1:0] ram_rdata;
    logic                      res_valid;
    logic                      res_ready;
    vfc_pkg::result_t          res;
    vfc_pkg::result_t          out_reg;
    logic                      m_tvalid_reg, m_tvalid_next;

    assign in_item = vfc_pkg::item_t'(s_tdata[vfc_pkg::IN_FIELDS_W-1:0]);

    vfc_ram #(
        .DEPTH  (vfc_pkg::VOXEL_COUNT),
        .ADDR_W (vfc_pkg::ADDR_W),
        .DATA_W (vfc_pkg::TYPE_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    vfc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_item   (in_item),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register loads when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = vfc_pkg::OUT_DATA_W'(out_reg);

`ifndef NO_ASSERTIONS
    a_count_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(out_reg.face_count) == $countones(out_reg.face_mask)))
        else $error("face count does not match face mask");

    a_empty_no_faces: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.voxel_type == '0) |-> (out_reg.face_mask == '0))
        else $error("empty voxel reports visible faces");

    a_no_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !res_valid)
        else $error("result offered right after input transfer");

    a_ram_idle_on_output_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |-> !ram_req.en)
        else $error("RAM access while result is handed off");
`endif

endmodule

FILE: dv/vfc_checker.sv
// vfc_checker: watches both stream channels, predicts face visibility and compares results.
`timescale 1ns / 1ps

module vfc_checker
    import vfc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [19:12] block_type, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] voxel_type, [13:8] face_mask, [16:14] face_count, rest zero
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending
);

    logic [TYPE_W-1:0] voxel_mirror [VOXEL_COUNT];
    result_t           faces_due [$];
    result_t           want;
    result_t           got;

    // off-cube neighbors read as empty
    function automatic logic [TYPE_W-1:0] mirror_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= CUBE_EDGE || y >= CUBE_EDGE || z >= CUBE_EDGE)
            return '0;
        return voxel_mirror[(x * CUBE_EDGE + y) * CUBE_EDGE + z];
    endfunction

    // applies a write to the mirror, then culls the addressed voxel
    function automatic result_t cull_item(logic kind, item_t it);
        result_t           r;
        logic [MASK_W-1:0] m;
        int                x;
        int                y;
        int                z;
        x = it.pos_x;
        y = it.pos_y;
        z = it.pos_z;
        r = '0;
        m = '0;
        if (kind == KIND_WRITE && x < CUBE_EDGE && y < CUBE_EDGE && z < CUBE_EDGE)
            voxel_mirror[(x * CUBE_EDGE + y) * CUBE_EDGE + z] = it.block_type;
        r.voxel_type = mirror_at(x, y, z);
        if (r.voxel_type != '0) begin
            m[0] = (mirror_at(x + 1, y, z) == '0);
            m[1] = (mirror_at(x - 1, y, z) == '0);
            m[2] = (mirror_at(x, y + 1, z) == '0);
            m[3] = (mirror_at(x, y - 1, z) == '0);
            m[4] = (mirror_at(x, y, z + 1) == '0);
            m[5] = (mirror_at(x, y, z - 1) == '0);
        end
        r.face_mask  = m;
        r.face_count = CNT_W'($countones(m));
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (voxel_mirror[i]) voxel_mirror[i] = '0;
            faces_due.delete();
            fail_count = 0;
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (faces_due.size() == 0) begin
                    $error("result transfer with nothing outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = faces_due.pop_front();
                    if (got.voxel_type !== want.voxel_type) begin
                        $error("voxel_type: expected %0d, actual %0d",
                               want.voxel_type, got.voxel_type);
                        fail_count++;
                    end
                    if (got.face_mask !== want.face_mask) begin
                        $error("face_mask: expected %b, actual %b",
                               want.face_mask, got.face_mask);
                        fail_count++;
                    end
                    if (got.face_count !== want.face_count) begin
                        $error("face_count: expected %0d, actual %0d",
                               want.face_count, got.face_count);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                faces_due.insert(faces_due.size(),
                                 cull_item(s_tuser[0], item_t'(s_tdata[IN_FIELDS_W-1:0])));
            pending <= faces_due.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for the voxel face cull block.
`timescale 1ns / 1ps

module tb_top;

    import vfc_pkg::*;

    localparam int SEGMENTS     = 12;
    localparam int SEG_ITEMS    = 96;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_LIMIT  = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending;

    // traffic modes shared by the sender and receiver processes
    bit calm;
    bit rush;
    bit hold_req;
    int win_x;
    int win_y;
    int win_z;

    voxel_face_cull dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vfc_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic sender_gap();
        int r;
        int n;
        n = 0;
        if (!calm && !rush) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                n = 0;
            else if (r < 90)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(8, 40);
        end
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic offer(input logic kind, input int x, input int y, input int z,
                         input int btype);
        item_t it;
        it.pos_x      = x[COORD_W-1:0];
        it.pos_y      = y[COORD_W-1:0];
        it.pos_z      = z[COORD_W-1:0];
        it.block_type = btype[TYPE_W-1:0];
        sender_gap();
        s_tuser  <= kind;
        s_tdata  <= IN_DATA_W'(it);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender stops until every outstanding result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // mostly packed into a 4x4x4 window so neighbors interact; the rest spans the cube
    task automatic random_item();
        int   x;
        int   y;
        int   z;
        int   btype;
        logic kind;
        if ($urandom_range(0, 99) < 70) begin
            x = win_x + $urandom_range(0, 3);
            y = win_y + $urandom_range(0, 3);
            z = win_z + $urandom_range(0, 3);
        end else begin
            x = $urandom_range(0, CUBE_EDGE - 1);
            y = $urandom_range(0, CUBE_EDGE - 1);
            z = $urandom_range(0, CUBE_EDGE - 1);
        end
        kind  = ($urandom_range(0, 99) < 45) ? KIND_WRITE : KIND_QUERY;
        btype = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(1, 255);
        offer(kind, x, y, z, btype);
    endtask

    function automatic int window_corner();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return 0;
        if (r == 1) return CUBE_EDGE - 4;
        return $urandom_range(0, CUBE_EDGE - 4);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int r;
        int n;
        m_tready = 1'b0;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(1, 12);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    n = $urandom_range(1, 4);
                end else begin
                    m_tready <= 1'b0;
                    n = $urandom_range(15, 60);
                end
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin
        int waited;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_WRITE;
        calm     = 1'b0;
        rush     = 1'b0;
        hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // store starts empty; query type field is ignored
        offer(KIND_QUERY, 0, 0, 0, 8'hFF);
        // lone corner voxel shows all six faces
        offer(KIND_WRITE, 0, 0, 0, 8'hFF);
        offer(KIND_WRITE, 1, 0, 0, 8'h01);
        offer(KIND_QUERY, 0, 0, 0, 8'h00);
        offer(KIND_WRITE, 15, 15, 15, 8'h80);
        offer(KIND_WRITE, 15, 15, 14, 8'h7F);
        offer(KIND_QUERY, 15, 15, 15, 8'hAA);
        // fully enclosed voxel culls every face
        offer(KIND_WRITE, 8, 8, 8, 8'h5A);
        offer(KIND_WRITE, 9, 8, 8, 8'h01);
        offer(KIND_WRITE, 7, 8, 8, 8'h02);
        offer(KIND_WRITE, 8, 9, 8, 8'h04);
        offer(KIND_WRITE, 8, 7, 8, 8'h08);
        offer(KIND_WRITE, 8, 8, 9, 8'h10);
        offer(KIND_WRITE, 8, 8, 7, 8'h20);
        offer(KIND_QUERY, 8, 8, 8, 8'h55);
        // clearing a neighbor reopens one face; clearing the voxel gives nothing
        offer(KIND_WRITE, 9, 8, 8, 8'h00);
        offer(KIND_QUERY, 8, 8, 8, 8'h00);
        offer(KIND_WRITE, 8, 8, 8, 8'h00);
        offer(KIND_QUERY, 0, 15, 0, 8'h00);
        offer(KIND_WRITE, 0, 15, 0, 8'h55);
        offer(KIND_WRITE, 15, 0, 15, 8'hAA);
        offer(KIND_QUERY, 15, 0, 15, 8'h00);
        drain_results();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            win_x = window_corner();
            win_y = window_corner();
            win_z = window_corner();
            if (seg == 9)
                drain_results();
            calm = (seg == 3);
            if (seg == 6) begin
                // receiver holds off while the sender keeps offering back to back
                hold_req = 1'b1;
                rush     = 1'b1;
            end
            for (int i = 0; i < SEG_ITEMS; i++)
                random_item();
            calm = 1'b0;
            rush = 1'b0;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
design/vfc_pkg.sv
design/vfc_ram.sv
design/vfc_ctrl.sv
design/voxel_face_cull.sv
dv/vfc_checker.sv
dv/tb_top.sv
